>>> hw/rtl/pctp_pkg.sv
package pctp_pkg;

  localparam int CW   = 32;
  localparam int RW   = CW - 1;
  localparam int MW   = CW + 1;
  localparam int SW   = CW + 1;
  localparam int D2W  = 2 * MW;
  localparam int NUMW = D2W + 1;
  localparam int NLO  = (NUMW + 1) / 2;
  localparam int NHI  = NUMW - NLO;
  localparam int NW   = NUMW + RW;
  localparam int SRW  = SW + 2;
  localparam int LANES = 4;

  typedef struct packed {
    logic signed [CW-1:0] centre_x;
    logic signed [CW-1:0] centre_y;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic [RW-1:0]        circle_radius;
  } in_t;

  typedef struct packed {
    logic                 valid_res;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
  } out_t;

  typedef struct packed {
    logic [MW-1:0]  adx;
    logic [MW-1:0]  ady;
    logic           ndx;
    logic           ndy;
    logic [RW-1:0]  r;
    logic [D2W-1:0] d2;
    logic           ok;
  } sb_t;

  typedef struct packed {
    logic            neg;
    logic [NUMW-1:0] mag;
  } smag_t;

endpackage

>>> hw/rtl/point_circle_tangent_points.sv
// Tangent points from an external point to a circle, signed fixed point with
// offsets returned relative to the centre. One item enters every cycle unless
// the result side stalls. The depth is set by the square root, which settles
// one root bit per stage, and by the four dividers, which settle one quotient
// bit per stage. When the result side stalls, the whole pipeline holds.
module point_circle_tangent_points (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pctp_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output pctp_pkg::out_t   out_data
);

  localparam int CW    = pctp_pkg::CW;
  localparam int RW    = pctp_pkg::RW;
  localparam int MW    = pctp_pkg::MW;
  localparam int SW    = pctp_pkg::SW;
  localparam int D2W   = pctp_pkg::D2W;
  localparam int NUMW  = pctp_pkg::NUMW;
  localparam int NLO   = pctp_pkg::NLO;
  localparam int NHI   = pctp_pkg::NHI;
  localparam int NW    = pctp_pkg::NW;
  localparam int SRW   = pctp_pkg::SRW;
  localparam int LANES = pctp_pkg::LANES;
  localparam int AW    = D2W + 2;

  function automatic pctp_pkg::smag_t ssum(input logic [NUMW-1:0] a, input logic an,
                                           input logic [NUMW-1:0] b, input logic bn);
    pctp_pkg::smag_t res;
    if (an == bn) begin
      res.mag = a + b;
      res.neg = an;
    end else if (a >= b) begin
      res.mag = a - b;
      res.neg = an;
    end else begin
      res.mag = b - a;
      res.neg = bn;
    end
    if (res.mag == '0) begin
      res.neg = 1'b0;
    end
    return res;
  endfunction

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: offsets and magnitudes.
  logic          s1_v_r;
  logic [MW-1:0] s1_adx_r, s1_ady_r;
  logic          s1_ndx_r, s1_ndy_r;
  logic [RW-1:0] s1_r_r;
  logic signed [MW-1:0] dx_c, dy_c;

  always_comb begin
    dx_c = $signed({in_data.point_x[CW-1], in_data.point_x})
         - $signed({in_data.centre_x[CW-1], in_data.centre_x});
    dy_c = $signed({in_data.point_y[CW-1], in_data.point_y})
         - $signed({in_data.centre_y[CW-1], in_data.centre_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ndx_r <= dx_c[MW-1];
      s1_ndy_r <= dy_c[MW-1];
      s1_adx_r <= dx_c[MW-1] ? MW'(-dx_c) : MW'(dx_c);
      s1_ady_r <= dy_c[MW-1] ? MW'(-dy_c) : MW'(dy_c);
      s1_r_r   <= in_data.circle_radius;
    end
  end

  // Stage 2: squares.
  logic           s2_v_r;
  logic [D2W-1:0] s2_xx_r, s2_yy_r;
  logic [2*RW-1:0] s2_rr_r;
  pctp_pkg::sb_t  s2_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_xx_r <= s1_adx_r * s1_adx_r;
      s2_yy_r <= s1_ady_r * s1_ady_r;
      s2_rr_r <= s1_r_r * s1_r_r;
      s2_sb_r <= '{adx: s1_adx_r, ady: s1_ady_r, ndx: s1_ndx_r, ndy: s1_ndy_r,
                   r: s1_r_r, d2: '0, ok: 1'b0};
    end
  end

  // Square root pipeline, index 0 is loaded with d2 and the discriminant.
  logic           sq_v_r    [0:SW];
  logic [SRW-1:0] sq_rem_r  [0:SW];
  logic [SW-1:0]  sq_root_r [0:SW];
  logic [D2W-1:0] sq_disc_r [0:SW];
  pctp_pkg::sb_t  sq_sb_r   [0:SW];
  logic [D2W-1:0] d2_c;
  logic           ok_c;

  always_comb begin
    d2_c = s2_xx_r + s2_yy_r;
    ok_c = (s2_sb_r.r != '0) && (d2_c > D2W'(s2_rr_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_disc_r[0] <= ok_c ? d2_c - D2W'(s2_rr_r) : '0;
      sq_sb_r[0]   <= '{adx: s2_sb_r.adx, ady: s2_sb_r.ady, ndx: s2_sb_r.ndx,
                        ndy: s2_sb_r.ndy, r: s2_sb_r.r, d2: d2_c, ok: ok_c};
    end
  end

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [SRW+1:0] t_c, trial_c;
    logic           ge_c;

    always_comb begin
      t_c     = {sq_rem_r[k], sq_disc_r[k][D2W-1-2*k -: 2]};
      trial_c = {{(SRW-SW){1'b0}}, sq_root_r[k], 2'b01};
      ge_c    = t_c >= trial_c;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k+1]  <= ge_c ? SRW'(t_c - trial_c) : SRW'(t_c);
        sq_root_r[k+1] <= {sq_root_r[k][SW-2:0], ge_c};
        sq_disc_r[k+1] <= sq_disc_r[k];
        sq_sb_r[k+1]   <= sq_sb_r[k];
      end
    end
  end

  // Products of the numerator terms.
  logic          m_v_r;
  logic [RW+MW-1:0] m_a_r, m_e_r;
  logic [MW+SW-1:0] m_b_r, m_c_r;
  pctp_pkg::sb_t m_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= sq_v_r[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_a_r  <= sq_sb_r[SW].r * sq_sb_r[SW].adx;
      m_e_r  <= sq_sb_r[SW].r * sq_sb_r[SW].ady;
      m_b_r  <= sq_sb_r[SW].ady * sq_root_r[SW];
      m_c_r  <= sq_sb_r[SW].adx * sq_root_r[SW];
      m_sb_r <= sq_sb_r[SW];
    end
  end

  // Signed sums of the numerators.
  logic            u_v_r;
  pctp_pkg::smag_t u_num_r [0:LANES-1];
  pctp_pkg::sb_t   u_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_v_r <= 1'b0;
    end else if (en) begin
      u_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_num_r[0] <= ssum(NUMW'(m_a_r), m_sb_r.ndx, NUMW'(m_b_r), !m_sb_r.ndy);
      u_num_r[1] <= ssum(NUMW'(m_e_r), m_sb_r.ndy, NUMW'(m_c_r), m_sb_r.ndx);
      u_num_r[2] <= ssum(NUMW'(m_a_r), m_sb_r.ndx, NUMW'(m_b_r), m_sb_r.ndy);
      u_num_r[3] <= ssum(NUMW'(m_e_r), m_sb_r.ndy, NUMW'(m_c_r), !m_sb_r.ndx);
      u_sb_r     <= m_sb_r;
    end
  end

  // Partial products of numerator times radius.
  logic              p_v_r;
  logic [NLO+RW-1:0] p_lo_r [0:LANES-1];
  logic [NHI+RW-1:0] p_hi_r [0:LANES-1];
  logic [LANES-1:0]  p_neg_r;
  pctp_pkg::sb_t     p_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= u_v_r;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_pp
    always_ff @(posedge clk) begin
      if (en) begin
        p_lo_r[l]  <= u_num_r[l].mag[NLO-1:0] * u_sb_r.r;
        p_hi_r[l]  <= u_num_r[l].mag[NUMW-1:NLO] * u_sb_r.r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_sb_r <= u_sb_r;
      for (int l = 0; l < LANES; l++) begin
        p_neg_r[l] <= u_num_r[l].neg;
      end
    end
  end

  // Divider pipeline, index 0 holds the top of the dividend and its low bits.
  logic             dv_v_r   [0:CW];
  logic [D2W-1:0]   dv_rem_r [0:CW][0:LANES-1];
  logic [CW-1:0]    dv_q_r   [0:CW][0:LANES-1];
  logic [CW-1:0]    dv_lo_r  [0:CW][0:LANES-1];
  logic [D2W-1:0]   dv_d2_r  [0:CW];
  logic [LANES-1:0] dv_neg_r [0:CW];
  logic             dv_ok_r  [0:CW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= p_v_r;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_n
    logic [NW-1:0] n_c;

    always_comb begin
      n_c = (NW'(p_hi_r[l]) << NLO) + NW'(p_lo_r[l]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[0][l] <= n_c[CW +: D2W];
        dv_lo_r[0][l]  <= n_c[CW-1:0];
        dv_q_r[0][l]   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d2_r[0]  <= p_sb_r.d2;
      dv_neg_r[0] <= p_neg_r;
      dv_ok_r[0]  <= p_sb_r.ok;
    end
  end

  for (genvar j = 0; j < CW; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_d2_r[j+1]  <= dv_d2_r[j];
        dv_neg_r[j+1] <= dv_neg_r[j];
        dv_ok_r[j+1]  <= dv_ok_r[j];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [D2W:0] t_c;
      logic         ge_c;

      always_comb begin
        t_c  = {dv_rem_r[j][l], dv_lo_r[j][l][CW-1-j]};
        ge_c = t_c >= {1'b0, dv_d2_r[j]};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[j+1][l] <= ge_c ? D2W'(t_c - {1'b0, dv_d2_r[j]}) : t_c[D2W-1:0];
          dv_q_r[j+1][l]   <= {dv_q_r[j][l][CW-2:0], ge_c};
          dv_lo_r[j+1][l]  <= dv_lo_r[j][l];
        end
      end
    end
  end

  // Rounding, saturation and sign.
  logic          out_v_r;
  pctp_pkg::out_t out_r;
  logic [CW-1:0] res_c [0:LANES-1];

  for (genvar l = 0; l < LANES; l++) begin : g_fin
    logic [D2W:0]  twice_c;
    logic [CW:0]   qr_c, lim_c, qs_c;

    always_comb begin
      twice_c  = {dv_rem_r[CW][l], 1'b0};
      qr_c     = {1'b0, dv_q_r[CW][l]} + (CW+1)'(twice_c >= {1'b0, dv_d2_r[CW]});
      lim_c    = (CW+1)'(1) << (CW - 1);
      if (!dv_neg_r[CW][l]) begin
        lim_c = lim_c - 1'b1;
      end
      qs_c     = (qr_c > lim_c) ? lim_c : qr_c;
      res_c[l] = !dv_ok_r[CW] ? '0 : dv_neg_r[CW][l] ? CW'(-qs_c) : CW'(qs_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.valid_res <= dv_ok_r[CW];
      out_r.first_x   <= res_c[0];
      out_r.first_y   <= res_c[1];
      out_r.second_x  <= res_c[2];
      out_r.second_y  <= res_c[3];
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |->
      out_data.first_x == '0 && out_data.first_y == '0 &&
      out_data.second_x == '0 && out_data.second_y == '0)
    else $error("Invalid result carries nonzero offsets.");

  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v_r[SW] |->
      AW'(sq_root_r[SW]) * AW'(sq_root_r[SW]) <= AW'(sq_disc_r[SW]) &&
      (AW'(sq_root_r[SW]) + 1'b1) * (AW'(sq_root_r[SW]) + 1'b1) > AW'(sq_disc_r[SW]))
    else $error("Square root stage result is not the floor root.");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[CW] && dv_ok_r[CW] |->
      dv_rem_r[CW][0] < dv_d2_r[CW] && dv_rem_r[CW][3] < dv_d2_r[CW])
    else $error("Divider remainder is not below the divisor.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(sq_root_r[SW]) && $stable(dv_q_r[CW][0]))
    else $error("Pipeline moved while the result was stalled.");

endmodule
